/* design/rtc_calendar_counter_unit_defines.svh */
// assertion macros shared by the real-time clock and calendar design
`ifndef RTC_CALENDAR_COUNTER_UNIT_DEFINES_SVH
`define RTC_CALENDAR_COUNTER_UNIT_DEFINES_SVH

// same-cycle implication, checked on the clock, off while in reset
`define RTCC_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on the clock, off while in reset
`define RTCC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/rtcc_pkg.sv */
// types, constants and month table for the real-time clock and calendar
`timescale 1ns / 1ps
`default_nettype none

package rtcc_pkg;

   localparam int unsigned OPCODE_WIDTH = 3;
   localparam int unsigned LOAD_WIDTH   = 14;
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 13;

   localparam logic [12:0] TPS_MIN   = 13'd8;
   localparam logic [12:0] TPS_MAX   = 13'd4096;
   localparam logic [12:0] TPS_RESET = 13'd800;

   localparam logic [6:0]  HUNDREDTHS_LAST = 7'd99;
   localparam logic [5:0]  SECOND_LAST  = 6'd59;
   localparam logic [5:0]  MINUTE_LAST  = 6'd59;
   localparam logic [4:0]  HOUR_LAST    = 5'd23;
   localparam logic [3:0]  MONTH_LAST   = 4'd12;
   localparam logic [13:0] YEAR_LAST    = 14'd9999;
   localparam logic [4:0]  DAY_LAST     = 5'd31;
   localparam logic [2:0]  WEEKDAY_LAST = 3'd7;
   localparam logic [3:0]  WEEK_DAYS    = 4'd7;

   typedef enum logic [OPCODE_WIDTH-1:0] {
      OP_TICK         = 3'd0,
      OP_LOAD_HOUR    = 3'd1,
      OP_LOAD_MINUTE  = 3'd2,
      OP_LOAD_MONTH   = 3'd3,
      OP_LOAD_YEAR    = 3'd4,
      OP_LOAD_DAY     = 3'd5,
      OP_LOAD_WEEKDAY = 3'd6,
      OP_LOAD_SECOND  = 3'd7
   } opcode_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_TICKS_PER_SECOND = 3'd0,
      CSR_ALARM_ENABLE     = 3'd1,
      CSR_ALARM_WEEKDAY    = 3'd2,
      CSR_ALARM_HOUR       = 3'd3,
      CSR_ALARM_MINUTE     = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [12:0] ticks_per_second;
      logic        alarm_enable;
      logic [2:0]  alarm_weekday;
      logic [4:0]  alarm_hour;
      logic [5:0]  alarm_minute;
   } cfg_type;

   typedef struct packed {
      logic [11:0] subsecond;
      logic [6:0]  hundredths;
      logic [5:0]  second;
      logic [5:0]  minute;
      logic [4:0]  hour;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [13:0] year;
      logic [2:0]  weekday;
      logic [5:0]  chime;
      logic        led;
      logic        buzzer;
   } state_type;

   localparam cfg_type CFG_RESET = '{
      ticks_per_second: TPS_RESET,
      alarm_enable:     1'b0,
      alarm_weekday:    3'd0,
      alarm_hour:       5'd0,
      alarm_minute:     6'd0
   };

   localparam state_type STATE_RESET = '{
      subsecond:  12'd0,
      hundredths: 7'd0,
      second:     6'd30,
      minute:     6'd30,
      hour:       5'd14,
      day:        5'd24,
      month:      4'd12,
      year:       14'd2019,
      weekday:    3'd2,
      chime:      6'd0,
      led:        1'b0,
      buzzer:     1'b0
   };

   // days in a month, zero for codes that name no month
   function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
      logic [4:0] days;
      begin
         case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                      days = 5'd30;
            4'd2:                                          days = leap ? 5'd29 : 5'd28;
            default:                                       days = 5'd0;
         endcase
         return days;
      end
   endfunction

endpackage

`default_nettype wire

/* design/rtcc_next_state.sv */
// next clock and calendar state for one tick or load word
`timescale 1ns / 1ps
`default_nettype none

module rtcc_next_state
   import rtcc_pkg::*;
(
   input  state_type         cur_state,
   input  cfg_type           cfg,
   input  opcode_type        opcode,
   input  logic [LOAD_WIDTH-1:0] load_value,
   output state_type         nxt_state
);

   logic [12:0] tps_sat;
   logic [11:0] tps_less_one;
   logic        second_tick;
   logic [5:0]  day_inc;
   logic [4:0]  len;
   logic [3:0]  weekday_inc;
   logic        alarm_hit;

   always_comb begin
      tps_sat = cfg.ticks_per_second;
      if (tps_sat < TPS_MIN) begin
         tps_sat = TPS_MIN;
      end
      if (tps_sat > TPS_MAX) begin
         tps_sat = TPS_MAX;
      end
      tps_less_one = 12'(tps_sat - 13'd1);
   end

   always_comb begin
      nxt_state   = cur_state;
      second_tick = 1'b0;
      day_inc     = {1'b0, cur_state.day} + 6'd1;
      weekday_inc = {1'b0, cur_state.weekday} + 4'd1;
      len         = month_days(cur_state.month, cur_state.year[1:0] == 2'b00);
      alarm_hit   = 1'b0;

      unique case (opcode)
         OP_TICK: begin
            if (cur_state.subsecond[2:0] == 3'd0) begin
               nxt_state.hundredths = (cur_state.hundredths >= HUNDREDTHS_LAST) ?
                                      7'd0 : cur_state.hundredths + 7'd1;
            end
            if (cur_state.subsecond == 12'd0) begin
               nxt_state.subsecond = tps_less_one;
               second_tick = 1'b1;
            end else begin
               nxt_state.subsecond = cur_state.subsecond - 12'd1;
            end
         end
         OP_LOAD_HOUR: begin
            if (load_value <= {9'd0, HOUR_LAST}) nxt_state.hour = load_value[4:0];
         end
         OP_LOAD_MINUTE: begin
            if (load_value <= {8'd0, MINUTE_LAST}) nxt_state.minute = load_value[5:0];
         end
         OP_LOAD_MONTH: begin
            if (load_value >= 14'd1 && load_value <= {10'd0, MONTH_LAST}) begin
               nxt_state.month = load_value[3:0];
            end
         end
         OP_LOAD_YEAR: begin
            if (load_value <= YEAR_LAST) nxt_state.year = load_value;
         end
         OP_LOAD_DAY: begin
            if (load_value >= 14'd1 && load_value <= {9'd0, DAY_LAST}) begin
               nxt_state.day = load_value[4:0];
            end
         end
         OP_LOAD_WEEKDAY: begin
            if (load_value >= 14'd1 && load_value <= {11'd0, WEEKDAY_LAST}) begin
               nxt_state.weekday = load_value[2:0];
            end
         end
         OP_LOAD_SECOND: begin
            if (load_value <= {8'd0, SECOND_LAST}) nxt_state.second = load_value[5:0];
         end
      endcase

      // one second gone: led, hourly chime, then the carry chain
      if (second_tick) begin
         nxt_state.led = ~cur_state.led;
         if (cur_state.minute == 6'd0 && cur_state.chime < {cur_state.hour, 1'b0}) begin
            nxt_state.buzzer = ~cur_state.buzzer;
            nxt_state.chime  = cur_state.chime + 6'd1;
         end
         if (cur_state.second >= SECOND_LAST) begin
            nxt_state.second = 6'd0;
            nxt_state.chime  = 6'd0;
            if (cur_state.minute >= MINUTE_LAST) begin
               nxt_state.minute = 6'd0;
               if (cur_state.hour >= HOUR_LAST) begin
                  nxt_state.hour    = 5'd0;
                  nxt_state.weekday = (weekday_inc > {1'b0, WEEKDAY_LAST}) ?
                                      3'(weekday_inc - WEEK_DAYS) : weekday_inc[2:0];
                  if (day_inc > {1'b0, len} && len != 5'd0) begin
                     nxt_state.day = 5'(day_inc - {1'b0, len});
                     if (cur_state.month >= MONTH_LAST) begin
                        nxt_state.month = 4'd1;
                        nxt_state.year  = (cur_state.year >= YEAR_LAST) ?
                                          14'd0 : cur_state.year + 14'd1;
                     end else begin
                        nxt_state.month = cur_state.month + 4'd1;
                     end
                  end else begin
                     nxt_state.day = day_inc[4:0];
                  end
               end else begin
                  nxt_state.hour = cur_state.hour + 5'd1;
               end
            end else begin
               nxt_state.minute = cur_state.minute + 6'd1;
            end
         end else begin
            nxt_state.second = cur_state.second + 6'd1;
         end
      end

      // alarm looks at the time after the tick
      alarm_hit = (opcode == OP_TICK) && cfg.alarm_enable &&
                  (cfg.alarm_weekday == 3'd0 || cfg.alarm_weekday == nxt_state.weekday) &&
                  cfg.alarm_hour == nxt_state.hour && cfg.alarm_minute == nxt_state.minute &&
                  nxt_state.subsecond == 12'd0;
      if (alarm_hit) begin
         nxt_state.buzzer = ~nxt_state.buzzer;
      end
   end

endmodule

`default_nettype wire

/* design/rtc_calendar_counter_unit.sv */
// real-time clock and calendar top level: state, config and result registers
//
// req channel: one word per tick or load. req_tuser carries the opcode
// (tick, or load of hour, minute, month, year, day, weekday, second) and
// req_tdata the load value, ignored on a tick; out-of-range loads change nothing.
// rsp channel: exactly one word per accepted req word, holding the full time,
// date, hundredths, led and buzzer levels as they stand after that word.
// csr channel: register index and data; 0 ticks per second (saturated to
// 8..4096), 1 alarm enable, 2 alarm weekday (0 any), 3 alarm hour, 4 minute.
// Write it only while no word is in flight.
// rsp_tvalid rises in the cycle after req acceptance; one word is taken per
// cycle while the result register is not stalled.
// A stalled rsp holds its word and req_tready drops only while the result
// register is full and not being taken.
// Reset restores 14:30:30, December 24 2019, weekday 2, 800 ticks per second,
// alarm off, led and buzzer low, and empties the result register.
`timescale 1ns / 1ps
`default_nettype none
`include "rtc_calendar_counter_unit_defines.svh"

module rtc_calendar_counter_unit
   import rtcc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // load_value [13:0], zero pad [15:14]
   input  logic [2:0]  req_tuser,   // opcode [2:0]

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // second_now [5:0], minute_now [11:6],
                                    // hour_now [16:12], day_now [21:17],
                                    // month_now [25:22], year_now [39:26],
                                    // weekday_now [42:40], hundredths_now [49:43],
                                    // led_level [50], buzzer_level [51], pad [55:52]

   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   state_type  state_ff;
   state_type  state_in;
   cfg_type    cfg_ff;
   logic       rsp_tvalid_ff;
   logic [55:0] rsp_tdata_ff;
   logic       in_accept;
   opcode_type opcode;

   assign opcode     = opcode_type'(req_tuser);
   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign in_accept  = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   rtcc_next_state u_next_state (
      .cur_state  (state_ff),
      .cfg        (cfg_ff),
      .opcode     (opcode),
      .load_value (req_tdata[LOAD_WIDTH-1:0]),
      .nxt_state  (state_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_TICKS_PER_SECOND: cfg_ff.ticks_per_second <= csr_data;
            CSR_ALARM_ENABLE:     cfg_ff.alarm_enable     <= csr_data[0];
            CSR_ALARM_WEEKDAY:    cfg_ff.alarm_weekday    <= csr_data[2:0];
            CSR_ALARM_HOUR:       cfg_ff.alarm_hour       <= csr_data[4:0];
            CSR_ALARM_MINUTE:     cfg_ff.alarm_minute     <= csr_data[5:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (in_accept) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (in_accept) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept) begin
         rsp_tdata_ff <= {4'd0, state_in.buzzer, state_in.led, state_in.hundredths,
                          state_in.weekday, state_in.year, state_in.month,
                          state_in.day, state_in.hour, state_in.minute, state_in.second};
      end
   end

   `RTCC_ASSERT_IMPL(a_stall_blocks_req, rsp_tvalid_ff && !rsp_tready, !req_tready, "req taken while result register stalled")
   `RTCC_ASSERT_NEXT(a_accept_gives_rsp, in_accept, rsp_tvalid_ff, "accepted word gave no result")
   `RTCC_ASSERT_IMPL(a_time_in_range, 1'b1, state_ff.second < 6'd60 && state_ff.minute < 6'd60 && state_ff.hour < 5'd24, "time field out of range")
   `RTCC_ASSERT_NEXT(a_led_only_on_tick, !(in_accept && opcode == OP_TICK), $stable(state_ff.led) && $stable(state_ff.subsecond), "led or subsecond moved without a tick")
   `RTCC_ASSERT_IMPL(a_rsp_mirrors_state, rsp_tvalid_ff, rsp_tdata_ff[5:0] == state_ff.second && rsp_tdata_ff[51] == state_ff.buzzer, "result word differs from clock state")

endmodule

`default_nettype wire
